// File: hdl/mdt_pkg.sv
package mdt_pkg;

  localparam int MAX_ATOMS = 4096;
  localparam int ADDR_W    = $clog2(MAX_ATOMS);

  localparam int POS_W   = 32;
  localparam int BOX_W   = 31;
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int RAM_W = 3 * POS_W;

  localparam int SQRT_STEPS = 32;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  // Request operation codes.
  localparam logic [1:0] OP_BASELINE = 2'd0;
  localparam logic [1:0] OP_REBUILD  = 2'd1;
  localparam logic [1:0] OP_MEASURE  = 2'd2;
  localparam logic [1:0] OP_IGNORE   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BOX_X = 2'd0;
  localparam logic [1:0] CFG_BOX_Y = 2'd1;
  localparam logic [1:0] CFG_BOX_Z = 2'd2;

  // Axis select codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sub;
    logic       fold;
    logic       mul;
    logic       acc;
    logic       max_upd;
    logic       sqrt_step;
    logic       finish;
    logic [1:0] axis;
  } mdt_cmd_t;

  typedef struct packed {
    logic is_measure;
    logic is_last;
    logic count_equal;
    logic out_free;
  } mdt_status_t;

endpackage

// File: hdl/mdt_ram.sv
module mdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hdl/mdt_ctrl.sv
module mdt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  input  logic                 in_last_atom,
  output logic                 in_stall,
  input  mdt_pkg::mdt_status_t status,
  output mdt_pkg::mdt_cmd_t    cmd
);
  import mdt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUB  = 8'b0000_0010,
    S_FOLD = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_MAX  = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            axis_r, axis_nxt;
  logic [SQRT_CNT_W-1:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_op != OP_IGNORE)) begin
          cmd.load = 1'b1;
          axis_nxt = AXIS_X;
          if (in_op == OP_MEASURE) begin
            state_nxt = S_SUB;
          end else if (in_last_atom) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_MAX;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_SUB;
        end
      end
      S_MAX: begin
        cmd.max_upd = 1'b1;
        step_nxt    = '0;
        if (!status.is_last) begin
          state_nxt = S_IDLE;
        end else if (status.count_equal) begin
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AXIS_X;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
    end
  end

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result loaded while the output register is still occupied");

  a_sqrt_only_on_measure_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_step |-> (status.is_measure && status.is_last && status.count_equal))
    else $error("square root running outside a matched measure sweep end");

  a_three_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && axis_r == AXIS_Z) |=> (state_r == S_MAX))
    else $error("maximum update did not follow the third axis");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_op == OP_MEASURE) |=> in_stall)
    else $error("new request taken while a measure item is in progress");

endmodule

// File: hdl/mdt_datapath.sv
module mdt_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [mdt_pkg::BOX_W-1:0]   cfg_wdata,
  input  logic [1:0]                  in_op,
  input  logic [mdt_pkg::ADDR_W-1:0]  in_atom_index,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_pos_z,
  input  logic                        in_last_atom,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_sweep_kind,
  output logic [31:0]                 out_max_displacement,
  output logic [31:0]                 out_build_version,
  output logic                        out_count_mismatch,
  input  mdt_pkg::mdt_cmd_t           cmd,
  output mdt_pkg::mdt_status_t        status
);
  import mdt_pkg::*;

  // Box lengths
  logic [BOX_W-1:0] box_x_r, box_y_r, box_z_r;

  // Captured request
  logic [1:0]       op_r;
  logic             last_r;
  logic [POS_W-1:0] px_r, py_r, pz_r;

  // Baseline store
  logic [RAM_W-1:0] ram_rdata;

  // Sweep state
  logic [COUNT_W-1:0] sweep_count_r, base_count_r;
  logic [63:0]        run_max_r;
  logic [31:0]        held_r, version_r;

  // Distance path
  logic signed [32:0] d_r, fd_r, fd_nxt;
  logic [63:0]        sq_r, acc_r;
  logic [POS_W-1:0]   pos_sel, base_sel;
  logic [BOX_W-1:0]   len_sel;
  logic signed [33:0] two_d, len_s, d_minus, d_plus;
  logic signed [65:0] prod;
  logic [64:0]        acc_sum;
  logic [63:0]        new_max;

  // Square root
  logic [63:0] v_r, res_r, bit_r, trial;

  // Output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_max_r, out_ver_r;
  logic        out_mis_r;

  logic        count_equal;
  logic [31:0] held_nxt, version_nxt;

  mdt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_ATOMS)
  ) u_base_ram (
    .clk  (clk),
    .en   (cmd.load),
    .we   (in_op != OP_MEASURE),
    .addr (in_atom_index),
    .wdata({in_pos_z, in_pos_y, in_pos_x}),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= '0;
      box_y_r <= '0;
      box_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X: box_x_r <= cfg_wdata;
        CFG_BOX_Y: box_y_r <= cfg_wdata;
        CFG_BOX_Z: box_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        pos_sel  = px_r;
        base_sel = ram_rdata[POS_W-1:0];
        len_sel  = box_x_r;
      end
      AXIS_Y: begin
        pos_sel  = py_r;
        base_sel = ram_rdata[2*POS_W-1:POS_W];
        len_sel  = box_y_r;
      end
      default: begin
        pos_sel  = pz_r;
        base_sel = ram_rdata[3*POS_W-1:2*POS_W];
        len_sel  = box_z_r;
      end
    endcase
  end

  // Minimum image: one fold towards the origin when the difference exceeds half a box.
  always_comb begin
    two_d   = {d_r, 1'b0};
    len_s   = signed'({3'b000, len_sel});
    d_minus = 34'(d_r) - len_s;
    d_plus  = 34'(d_r) + len_s;
    fd_nxt  = d_r;
    if (len_sel != '0) begin
      if (two_d > len_s) begin
        fd_nxt = d_minus[32:0];
      end else if (two_d < -len_s) begin
        fd_nxt = d_plus[32:0];
      end
    end
  end

  assign prod    = fd_r * fd_r;
  assign acc_sum = {1'b0, acc_r} + {1'b0, sq_r};
  assign new_max = (acc_r > run_max_r) ? acc_r : run_max_r;
  assign trial   = res_r + bit_r;

  assign count_equal = (sweep_count_r == base_count_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      last_r <= in_last_atom;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pz_r   <= in_pos_z;
    end
    if (cmd.sub) begin
      d_r <= signed'({pos_sel[POS_W-1], pos_sel}) - signed'({base_sel[POS_W-1], base_sel});
    end
    if (cmd.fold) begin
      fd_r <= fd_nxt;
    end
    if (cmd.mul) begin
      sq_r <= prod[63:0];
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.acc) begin
      acc_r <= acc_sum[64] ? '1 : acc_sum[63:0];
    end
    if (cmd.max_upd) begin
      v_r   <= new_max;
      res_r <= '0;
      bit_r <= SQRT_BIT0;
    end else if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_comb begin
    held_nxt    = held_r;
    version_nxt = version_r;
    if (op_r == OP_MEASURE) begin
      if (count_equal) begin
        held_nxt = res_r[31:0];
      end
    end else begin
      held_nxt = '0;
      if (op_r == OP_REBUILD) begin
        version_nxt = version_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_count_r <= '0;
      base_count_r  <= '0;
      run_max_r     <= '0;
      held_r        <= '0;
      version_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.load && sweep_count_r != COUNT_MAX) begin
        sweep_count_r <= sweep_count_r + 1'b1;
      end
      if (cmd.max_upd) begin
        run_max_r <= new_max;
      end
      if (cmd.finish) begin
        sweep_count_r <= '0;
        run_max_r     <= '0;
        held_r        <= held_nxt;
        version_r     <= version_nxt;
        if (op_r != OP_MEASURE) begin
          base_count_r <= sweep_count_r;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_kind_r <= op_r;
      out_max_r  <= held_nxt;
      out_ver_r  <= version_nxt;
      out_mis_r  <= (op_r == OP_MEASURE) && !count_equal;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sweep_kind       = out_kind_r;
  assign out_max_displacement = out_max_r;
  assign out_build_version    = out_ver_r;
  assign out_count_mismatch   = out_mis_r;

  assign status.is_measure  = (op_r == OP_MEASURE);
  assign status.is_last     = last_r;
  assign status.count_equal = count_equal;
  assign status.out_free    = !out_valid_r || !out_stall;

  a_sweep_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (sweep_count_r == '0 && run_max_r == '0))
    else $error("sweep state not cleared at the end of a sweep");

  a_mismatch_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && op_r == OP_MEASURE && !count_equal)
      |=> (out_count_mismatch && $stable(held_r)))
    else $error("count mismatch altered the held displacement");

  a_rebuild_bumps_version: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && op_r == OP_REBUILD) |=> (version_r == $past(version_r) + 32'd1))
    else $error("rebuild did not advance the build version");

  a_baseline_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && op_r != OP_MEASURE)
      |=> (out_max_displacement == '0 && !out_count_mismatch))
    else $error("baseline sweep reported a displacement or mismatch");

endmodule

// File: hdl/max_displacement_tracker_top.sv
// Maximum displacement tracker for a neighbour list. Atom positions stream in one request per
// atom, signed Q16.16. Baseline and rebuild requests store the position in an on-chip memory of
// 4096 entries, so a baseline sweep streams at one atom per cycle up to its last request. A
// measure request does a registered memory read, then for each axis passes through one shared
// path (subtract, minimum image fold, 33 x 33 bit square, saturating accumulate) and updates the
// running maximum. The last request of any sweep ends in a finish step that loads the result
// register; before that, the last measure request of a sweep whose count matches the baseline
// also runs a square root, one result bit per cycle. A result is given only on a request marked
// last; it waits in an output register while the next request is taken, and a further sweep end
// holds the input stalled until that register is free. Box lengths are to be written through the
// configuration port while the block is idle; the block itself does not enforce this. Zero marks
// an axis as not periodic. Baseline entries that were never written read back undefined.
module max_displacement_tracker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [mdt_pkg::BOX_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [mdt_pkg::ADDR_W-1:0]  in_atom_index,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_pos_z,
  input  logic                        in_last_atom,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_sweep_kind,
  output logic [31:0]                 out_max_displacement,
  output logic [31:0]                 out_build_version,
  output logic                        out_count_mismatch
);
  import mdt_pkg::*;

  mdt_cmd_t    cmd;
  mdt_status_t status;

  mdt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_op       (in_op),
    .in_last_atom(in_last_atom),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  mdt_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_op               (in_op),
    .in_atom_index       (in_atom_index),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .in_last_atom        (in_last_atom),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sweep_kind      (out_sweep_kind),
    .out_max_displacement(out_max_displacement),
    .out_build_version   (out_build_version),
    .out_count_mismatch  (out_count_mismatch),
    .cmd                 (cmd),
    .status              (status)
  );

endmodule
